### hw/rtl/ease_pkg.sv
// Package: types, constants and the quarter-wave sine table generator for the easing core.
package ease_pkg;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned SineDepth  = 256;
  localparam int unsigned SineIdxW   = 8;
  localparam int unsigned AccW       = 72;
  localparam int unsigned MulAW      = 34;
  localparam int unsigned MulBW      = 24;

  localparam logic signed [AccW-1:0] OneQ  = AccW'(1) << FracBits;
  localparam logic signed [AccW-1:0] HalfQ = AccW'(1) << (FracBits - 1);
  localparam logic signed [AccW-1:0] C1Q   = AccW'(111515);
  localparam logic signed [AccW-1:0] C2Q   = AccW'(170060);

  localparam logic [2:0] CfgStart = 3'd0;
  localparam logic [2:0] CfgEnd   = 3'd1;
  localparam logic [2:0] CfgSpan  = 3'd2;
  localparam logic [2:0] CfgDelay = 3'd3;
  localparam logic [2:0] CfgCurve = 3'd4;
  localparam logic [2:0] CfgRep   = 3'd5;
  localparam logic [2:0] CfgBnc   = 3'd6;

  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quot;
  } div_rsp_t;

  function automatic logic [16:0] sine_entry(input int unsigned k);
    logic [63:0] x, x2, term;
    logic signed [63:0] sum;
    logic [63:0] r;
    begin
      x    = (64'd1686629713 * 64'(k) + 64'(SineDepth / 2)) / 64'(SineDepth);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - signed'(term);
        else sum = sum + signed'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      r = (64'(sum) + 64'd8192) >> 14;
      return r[16:0];
    end
  endfunction

endpackage

### hw/rtl/ease_div.sv
// Restoring divider, one quotient bit per cycle: num(33+16 bits) / den.
module ease_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ease_pkg::div_req_t req_i,
  output ease_pkg::div_rsp_t rsp_o
);
  import ease_pkg::*;

  localparam int unsigned NumW = 33 + FracBits;

  logic [NumW-1:0] num_q, num_d;
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     den_q, den_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [33:0]     trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[NumW-1]} - {2'b0, den_q};
    if (req_i.start) begin
      num_d  = {req_i.num, FracBits'(0)};
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) rem_d = trial[32:0];
      else rem_d = {rem_q[31:0], num_q[NumW-1]};
      num_d = {num_q[NumW-2:0], ~trial[33]};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q[32:0];
endmodule

### hw/rtl/ease_mul.sv
// Shared signed multiply unit: registered (a*b)/ONE truncated toward zero.
module ease_mul (
  input  logic                              clk_i,
  input  logic signed [ease_pkg::MulAW-1:0] a_i,
  input  logic signed [ease_pkg::MulBW-1:0] b_i,
  output logic signed [ease_pkg::AccW-1:0]  p_o
);
  import ease_pkg::*;

  localparam int unsigned ProdW = MulAW + MulBW;
  localparam logic signed [ProdW-1:0] RoundQ = ProdW'((1 << FracBits) - 1);

  logic signed [ProdW-1:0] prod, adj;

  always_comb begin
    prod = a_i * b_i;
    adj  = prod[ProdW-1] ? prod + RoundQ : prod;
  end

  always_ff @(posedge clk_i) begin
    p_o <= AccW'(adj >>> FracBits);
  end
endmodule

### hw/rtl/easing_interpolator_core.sv
// Top level of the easing interpolator: tick channel in, eased value out.
//
// Usage: configuration registers are written through cfg_we_i/cfg_addr_i/
// cfg_data_i (index 0 start, 1 end, 2 span, 3 delay, 4 curve, 5 repeat,
// 6 bounce) while the block is idle. Each slave transfer carries a 16-bit
// step in s_axis_tdata. One master transfer answers each tick: tdata holds
// the Q16.16 value; tuser bit 0 is value_updated, bit 1 finished.
// Flow: done or delay ticks put their result out at the accepting edge.
// Active ticks that do not end the pass first run a divide for the progress
// fraction, which a pass-ending tick skips; then up to four products go
// through one shared registered multiplier under a small sequencer. One
// tick is in flight at a time.
// Reset clears the timing state, loads the register defaults and empties
// the output register. A stalled receiver holds the result in the output
// register; the next tick is accepted once that result is transferred.
module easing_interpolator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] step_ticks
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] eased_value
  output logic [1:0]  m_axis_tuser   // [0] value_updated, [1] finished
);
  import ease_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDiv   = 4'd1;
  localparam logic [3:0] StPrep  = 4'd2;
  localparam logic [3:0] StMul   = 4'd3;
  localparam logic [3:0] StFinal = 4'd4;
  localparam logic [3:0] StOut   = 4'd5;
  localparam logic [3:0] StSin   = 4'd6;

  logic [16:0] sine_rom [SineDepth+1];
  always_comb begin
    for (int k = 0; k <= SineDepth; k++) sine_rom[k] = sine_entry(k);
  end

  logic signed [31:0] start_q, end_q;
  logic [31:0] span_q, delay_q;
  logic [3:0]  curve_q;
  logic        rep_q, bnc_q;

  logic [31:0] dcnt_q;
  logic [32:0] ptime_q;
  logic        fwd_q, done_q;
  logic [31:0] held_q;

  logic [3:0]  st_q;
  logic [3:0]  op_q;
  logic        ended_q;
  logic signed [AccW-1:0] t_q, r0_q, r1_q, ma_q, mb_q;
  logic        sin_neg_q, sin_half_q;
  logic [31:0] oval_q;
  logic [1:0]  ouser_q;
  logic        ovalid_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic signed [AccW-1:0] mp;

  ease_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  ease_mul u_mul (.clk_i, .a_i(ma_q[MulAW-1:0]), .b_i(mb_q[MulBW-1:0]), .p_o(mp));

  logic        in_acc;
  logic [32:0] pt_new;
  logic [32:0] dsum;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == StIdle) && !ovalid_q;
  assign pt_new = ptime_q + 33'(s_axis_tdata);
  assign dsum = {1'b0, dcnt_q} + 33'(s_axis_tdata);

  // sine lookup of sin_arg (registered r0_q)
  logic signed [AccW-1:0] s, u, v, sin_arg, sin_val;
  logic [FracBits+SineIdxW-1:0] pos;
  logic [16:0] sa, sb, sd;
  logic [33:0] sprod;
  always_comb begin
    s = t_q - OneQ;
    u = t_q <<< 1;
    v = u - (OneQ <<< 1);
    sin_arg = r0_q;
    pos = (FracBits+SineIdxW)'(sin_arg) * (FracBits+SineIdxW)'(SineDepth);
    sa = sine_rom[{1'b0, pos[FracBits+SineIdxW-1:FracBits]}];
    sb = sine_rom[{1'b0, pos[FracBits+SineIdxW-1:FracBits]} + 9'd1];
    if (sb < sa) sb = sa;
    sd = sb - sa;
    sprod = sd * pos[FracBits-1:0];
    if (sin_arg <= 0) sin_val = '0;
    else if (sin_arg >= OneQ) sin_val = AccW'(sine_rom[SineDepth]);
    else sin_val = AccW'(sa) + AccW'(sprod[33:FracBits]);
  end

  function automatic logic signed [AccW-1:0] half(input logic signed [AccW-1:0] x);
    return (x < 0) ? -((-x) >>> 1) : (x >>> 1);
  endfunction

  logic signed [AccW-1:0] diff, fromv, val;
  always_comb begin
    fromv = AccW'(start_q);
    diff  = AccW'(end_q) - fromv;
    val   = fromv + mp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0; end_q <= 32'sd65536; span_q <= 32'd1; delay_q <= '0;
      curve_q <= '0; rep_q <= 1'b0; bnc_q <= 1'b0;
      dcnt_q <= '0; ptime_q <= '0; fwd_q <= 1'b1; done_q <= 1'b0; held_q <= '0;
      st_q <= StIdle; op_q <= '0; ended_q <= 1'b0;
      ovalid_q <= 1'b0; oval_q <= '0; ouser_q <= '0;
      t_q <= '0; r0_q <= '0; r1_q <= '0; ma_q <= '0; mb_q <= '0;
      sin_neg_q <= 1'b0; sin_half_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgStart: start_q <= cfg_data_i;
          CfgEnd:   end_q   <= cfg_data_i;
          CfgSpan:  span_q  <= cfg_data_i;
          CfgDelay: delay_q <= cfg_data_i;
          CfgCurve: curve_q <= cfg_data_i[3:0];
          CfgRep:   rep_q   <= cfg_data_i[0];
          CfgBnc:   bnc_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (in_acc) begin
            if (done_q) begin
              oval_q <= held_q; ouser_q <= 2'b10; ovalid_q <= 1'b1;
            end else if (dcnt_q < delay_q) begin
              dcnt_q <= dsum[32] ? 32'hFFFF_FFFF : dsum[31:0];
              oval_q <= held_q; ouser_q <= 2'b00; ovalid_q <= 1'b1;
            end else begin
              ptime_q <= pt_new;
              ended_q <= pt_new >= {1'b0, span_q};
              st_q <= (pt_new >= {1'b0, span_q}) ? StPrep : StDiv;
            end
          end
        end
        StDiv: if (div_rsp.done) st_q <= StPrep;
        StPrep: begin
          // progress t and setup of the first multiply or the sine argument per curve
          logic signed [AccW-1:0] raw, tt, ss, uu, vv;
          raw = ended_q ? OneQ : AccW'(div_rsp.quot);
          tt = fwd_q ? raw : OneQ - raw;
          ss = tt - OneQ; uu = tt <<< 1; vv = uu - (OneQ <<< 1);
          t_q <= tt;
          op_q <= 4'd0;
          unique case (curve_q)
            4'd1, 4'd4, 4'd10: begin ma_q <= tt; mb_q <= tt; st_q <= StMul; end
            4'd2: begin ma_q <= tt; mb_q <= (OneQ <<< 1) - tt; st_q <= StMul; end
            4'd3: begin
              ma_q <= tt; mb_q <= (tt < HalfQ) ? tt : (OneQ <<< 2) - uu; st_q <= StMul;
            end
            4'd5, 4'd11: begin ma_q <= ss; mb_q <= ss; st_q <= StMul; end
            4'd6: begin
              ma_q <= (tt < HalfQ) ? tt : ss; mb_q <= (tt < HalfQ) ? tt : vv;
              r1_q <= vv; st_q <= StMul;
            end
            4'd12: begin
              ma_q <= (tt < HalfQ) ? uu : vv; mb_q <= (tt < HalfQ) ? uu : vv;
              st_q <= StMul;
            end
            4'd7: begin r0_q <= OneQ - tt; sin_neg_q <= 1'b1; sin_half_q <= 1'b0; st_q <= StSin; end
            4'd8: begin r0_q <= tt; sin_neg_q <= 1'b0; sin_half_q <= 1'b0; st_q <= StSin; end
            4'd9: begin
              r0_q <= (tt <= HalfQ) ? OneQ - uu : uu - OneQ;
              sin_neg_q <= (tt <= HalfQ); sin_half_q <= 1'b1; st_q <= StSin;
            end
            default: begin ma_q <= diff; mb_q <= tt; st_q <= StFinal; end
          endcase
        end
        StSin: begin
          logic signed [AccW-1:0] ee;
          ee = sin_neg_q ? OneQ - sin_val : sin_val;
          if (sin_half_q) ee = sin_neg_q ? half(OneQ - sin_val) : half(OneQ + sin_val);
          ma_q <= diff; mb_q <= ee; st_q <= StFinal;
        end
        StMul: begin
          // op_q steps: 0 issue wait, odd = result ready
          op_q <= op_q + 4'd1;
          if (op_q == 4'd1) begin
            r0_q <= mp;
            unique case (curve_q)
              4'd1: begin ma_q <= diff; mb_q <= mp; st_q <= StFinal; end
              4'd2: begin ma_q <= diff; mb_q <= mp; st_q <= StFinal; end
              4'd3: begin
                ma_q <= diff; mb_q <= (t_q < HalfQ) ? (mp <<< 1) : mp - OneQ;
                st_q <= StFinal;
              end
              4'd4: begin ma_q <= mp; mb_q <= t_q; end
              4'd5: begin ma_q <= mp; mb_q <= s; end
              4'd6: begin ma_q <= mp; mb_q <= (t_q < HalfQ) ? t_q : r1_q; end
              4'd10: begin ma_q <= C1Q + OneQ; mb_q <= t_q; end
              4'd11: begin ma_q <= C1Q + OneQ; mb_q <= s; end
              default: begin ma_q <= C2Q + OneQ; mb_q <= (t_q < HalfQ) ? u : v; end
            endcase
          end else if (op_q == 4'd3) begin
            logic signed [AccW-1:0] ee;
            ee = mp;
            unique case (curve_q)
              4'd4: ee = mp;
              4'd5: ee = mp + OneQ;
              4'd6: ee = (t_q < HalfQ) ? (mp <<< 2) : mp + OneQ;
              default: ee = mp;
            endcase
            if (curve_q == 4'd10 || curve_q == 4'd11 || curve_q == 4'd12) begin
              ma_q <= r0_q;
              if (curve_q == 4'd10) mb_q <= mp - C1Q;
              else if (curve_q == 4'd11) mb_q <= mp + C1Q;
              else mb_q <= (t_q < HalfQ) ? mp - C2Q : mp + C2Q;
            end else begin
              ma_q <= diff; mb_q <= ee; st_q <= StFinal;
            end
          end else if (op_q == 4'd5) begin
            logic signed [AccW-1:0] ee;
            if (curve_q == 4'd10) ee = mp;
            else if (curve_q == 4'd11) ee = mp + OneQ;
            else ee = (t_q < HalfQ) ? half(mp) : half(mp + (OneQ <<< 1));
            ma_q <= diff; mb_q <= ee; st_q <= StFinal;
          end
        end
        StFinal: begin
          op_q <= op_q + 4'd1;
          if (op_q[0]) st_q <= StOut;
        end
        StOut: begin
          logic [31:0] sat;
          if (val > AccW'(64'sh7FFF_FFFF)) sat = 32'h7FFF_FFFF;
          else if (val < -AccW'(64'sh8000_0000)) sat = 32'h8000_0000;
          else sat = val[31:0];
          held_q <= sat; oval_q <= sat;
          ouser_q <= {ended_q && !rep_q, 1'b1};
          ovalid_q <= 1'b1;
          if (ended_q) begin
            if (rep_q) begin
              ptime_q <= '0;
              if (bnc_q) fwd_q <= !fwd_q;
            end else done_q <= 1'b1;
          end
          op_q <= '0;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    div_req.start = in_acc && !done_q && !(dcnt_q < delay_q) && !(pt_new >= {1'b0, span_q});
    div_req.num   = pt_new;
    div_req.den   = span_q;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = oval_q;
  assign m_axis_tuser  = ouser_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == held_q))
    else $error("updated result differs from held value");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> (m_axis_tvalid && m_axis_tuser[1]))
    else $error("finish without finished result");
endmodule

### bench/easing_checker.sv
// Checker for the easing core: tracks config writes, predicts each tick and compares results.
module easing_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic [1:0]  m_tuser_i,
  output int          fail_count_o,
  output int          pending_o
);
  import ease_pkg::*;

  localparam longint OneFx  = 64'sd1 << 16;
  localparam longint HalfFx = 64'sd1 << 15;

  typedef enum logic [3:0] {
    CURVE_LINEAR, QUAD_IN, QUAD_OUT, QUAD_INOUT, CUBIC_IN, CUBIC_OUT, CUBIC_INOUT,
    SINE_IN, SINE_OUT, SINE_INOUT, BACK_IN, BACK_OUT, BACK_INOUT
  } curve_e;

  typedef struct packed {
    logic [31:0] value;
    logic        updated;
    logic        finished;
  } tick_result_t;

  tick_result_t expected_q[$];
  int           fails;

  logic [31:0] start_val, end_val, span, delay;
  logic [3:0]  curve;
  logic        rep_en, bnc_en;

  logic [31:0] delay_count;
  logic [32:0] pass_time;
  logic        forward, done;
  logic [31:0] held;

  longint unsigned sine_lut[SineDepth+1];
  longint back_k1, back_k2;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic longint unsigned lut_point(longint unsigned k);
    longint unsigned x, x2, term;
    longint acc;
    x    = (64'd1686629713 * k + 64'd128) / 64'd256;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    return (longint'(acc) + 64'd8192) >> 14;
  endfunction

  function automatic longint fx(longint a, longint b);
    return (a * b) / OneFx;
  endfunction

  function automatic longint quarter_sin(longint t);
    longint unsigned pos, idx, frac, a, b;
    if (t <= 0) return 0;
    if (t >= OneFx) return longint'(sine_lut[SineDepth]);
    pos  = longint'(t) * SineDepth;
    idx  = pos >> 16;
    frac = pos & 64'hFFFF;
    if (idx >= SineDepth) return longint'(sine_lut[SineDepth]);
    a = sine_lut[idx];
    b = sine_lut[idx+1];
    if (b < a) b = a;
    return longint'(a + (((b - a) * frac) >> 16));
  endfunction

  function automatic longint eased_fraction(longint t);
    longint s, u, v;
    s = t - OneFx;
    u = 2 * t;
    v = u - 2 * OneFx;
    case (curve)
      QUAD_IN:     return fx(t, t);
      QUAD_OUT:    return fx(t, 2 * OneFx - t);
      QUAD_INOUT:  return t < HalfFx ? 2 * fx(t, t) : -OneFx + fx(4 * OneFx - u, t);
      CUBIC_IN:    return fx(fx(t, t), t);
      CUBIC_OUT:   return fx(fx(s, s), s) + OneFx;
      CUBIC_INOUT: return t < HalfFx ? 4 * fx(fx(t, t), t) : fx(fx(s, v), v) + OneFx;
      SINE_IN:     return OneFx - quarter_sin(OneFx - t);
      SINE_OUT:    return quarter_sin(t);
      SINE_INOUT:  return t <= HalfFx ? (OneFx - quarter_sin(OneFx - u)) / 2
                                      : (OneFx + quarter_sin(u - OneFx)) / 2;
      BACK_IN:     return fx(fx(t, t), fx(back_k1 + OneFx, t) - back_k1);
      BACK_OUT:    return fx(fx(s, s), fx(back_k1 + OneFx, s) + back_k1) + OneFx;
      BACK_INOUT:  return t < HalfFx ? fx(fx(u, u), fx(back_k2 + OneFx, u) - back_k2) / 2
                     : (fx(fx(v, v), fx(back_k2 + OneFx, v) + back_k2) + 2 * OneFx) / 2;
      default:     return t;
    endcase
  endfunction

  function automatic tick_result_t advance_tick(logic [15:0] step);
    tick_result_t r;
    longint unsigned sum;
    longint raw, t, e, from, diff, val;
    logic ended;
    r = '0;
    if (done) begin
      r.value = held;
      r.finished = 1'b1;
      return r;
    end
    if (delay_count < delay) begin
      sum = longint'(delay_count) + step;
      delay_count = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
      r.value = held;
      return r;
    end
    pass_time = pass_time + 33'(step);
    ended = {31'd0, pass_time} >= {32'd0, span};
    if (ended) raw = OneFx;
    else raw = longint'((64'(pass_time) << 16) / 64'(span));
    t = forward ? raw : OneFx - raw;
    e = eased_fraction(t);
    from = longint'($signed(start_val));
    diff = longint'($signed(end_val)) - from;
    val = from + (diff * e) / OneFx;
    if (val > 64'sd2147483647) val = 64'sd2147483647;
    if (val < -64'sd2147483648) val = -64'sd2147483648;
    held = val[31:0];
    if (ended) begin
      if (rep_en) begin
        pass_time = '0;
        if (bnc_en) forward = !forward;
      end else begin
        done = 1'b1;
        r.finished = 1'b1;
      end
    end
    r.value = held;
    r.updated = 1'b1;
    return r;
  endfunction

  initial begin
    for (int k = 0; k <= SineDepth; k++) sine_lut[k] = lut_point(k);
    back_k1 = (64'd7308230452 + 64'd32768) >> 16;
    back_k2 = (64'd11145051439 + 64'd32768) >> 16;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t got, want;
    if (!rst_ni) begin
      expected_q.delete();
      fails = 0;
      start_val = 32'd0;
      end_val = 32'd65536;
      span = 32'd1;
      delay = 32'd0;
      curve = CURVE_LINEAR;
      rep_en = 1'b0;
      bnc_en = 1'b0;
      delay_count = '0;
      pass_time = '0;
      forward = 1'b1;
      done = 1'b0;
      held = '0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = '{value: m_tdata_i, updated: m_tuser_i[0], finished: m_tuser_i[1]};
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: value %0d", $signed(m_tdata_i));
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value) begin
            $error("eased_value: expected %0d, got %0d", $signed(want.value),
                   $signed(got.value));
            fails++;
          end
          if (got.updated !== want.updated) begin
            $error("value_updated: expected %0b, got %0b", want.updated, got.updated);
            fails++;
          end
          if (got.finished !== want.finished) begin
            $error("finished: expected %0b, got %0b", want.finished, got.finished);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgStart: start_val = cfg_data_i;
          CfgEnd:   end_val = cfg_data_i;
          CfgSpan:  span = cfg_data_i;
          CfgDelay: delay = cfg_data_i;
          CfgCurve: curve = cfg_data_i[3:0];
          CfgRep:   rep_en = cfg_data_i[0];
          CfgBnc:   bnc_en = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) expected_q = {expected_q, advance_tick(s_tdata_i)};
    end
  end
endmodule

### bench/tb_easing_interpolator_core.sv
// Testbench top: drives config and tick stimulus into the easing core and reports the verdict.
module tb_easing_interpolator_core;
  import ease_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count, pending;
  logic        src_no_gaps = 1'b0;
  logic        sink_no_stalls = 1'b0;
  int          ticks_sent = 0;

  always #2 clk_i = ~clk_i;

  easing_interpolator_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  easing_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tuser_i(m_axis_tuser), .fail_count_o(fail_count), .pending_o(pending)
  );

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // wait for the block to drain, then write a full register set
  task automatic load_config(logic [31:0] sv, logic [31:0] ev, logic [31:0] sp,
                             logic [31:0] dl, logic [3:0] cv, logic rp, logic bn);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    reg_write(CfgStart, sv);
    reg_write(CfgEnd, ev);
    reg_write(CfgSpan, sp);
    reg_write(CfgDelay, dl);
    reg_write(CfgCurve, {28'd0, cv});
    reg_write(CfgRep, {31'd0, rp});
    reg_write(CfgBnc, {31'd0, bn});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tick(logic [15:0] step);
    int gap;
    gap = src_no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= step;
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 9))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 2000000);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  function automatic logic [15:0] pick_step(logic [31:0] sp);
    int unsigned lim;
    lim = (sp > 32'd400) ? 100 : sp / 4 + 1;
    case ($urandom_range(0, 15))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, lim));
    endcase
  endfunction

  // receiver: random stall per result, with stretches of none
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = sink_no_stalls ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin
    logic [31:0] sp;
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults, then a delay that these ticks do not reach
    send_tick(16'd0);
    end_burst();
    load_config(32'd0, 32'd65536, 32'd1, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b0);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    end_burst();
    // every curve over the full value range, with repeat and bounce enabled
    for (int c = 0; c <= 12; c++) begin
      load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd4, 32'd0, c[3:0], 1'b1, 1'b1);
      send_tick(16'd1);
      send_tick(16'd2);
      end_burst();
    end

    while (ticks_sent < 1150) begin
      sp = pick_span();
      src_no_gaps <= ($urandom_range(0, 4) == 0);
      sink_no_stalls <= ($urandom_range(0, 4) == 0);
      load_config(pick_value(), pick_value(), sp,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000) : 32'd0,
                  4'($urandom_range(0, 12)), 1'b1, 1'($urandom_range(0, 1)));
      n = $urandom_range(10, 50);
      repeat (n) send_tick(pick_step(sp));
      end_burst();
    end

    // single-shot: runs to completion and stays finished
    src_no_gaps <= 1'b0;
    sink_no_stalls <= 1'b0;
    load_config(pick_value(), pick_value(), 32'd20, 32'd0, 4'($urandom_range(0, 12)),
                1'b0, 1'b0);
    repeat (30) send_tick(16'($urandom_range(0, 3)));
    end_burst();

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

### easing_interpolator_core.f
hw/rtl/ease_pkg.sv
hw/rtl/ease_div.sv
hw/rtl/ease_mul.sv
hw/rtl/easing_interpolator_core.sv
bench/easing_checker.sv
bench/tb_easing_interpolator_core.sv
